// ===== design/ctt_pkg.sv =====
// Shared types, character codes and helpers for the config text tokenizer.
`timescale 1ns / 1ps

package ctt_pkg;

  // Token kinds
  localparam logic [1:0] KIND_IDENT  = 2'd0;
  localparam logic [1:0] KIND_STRING = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // Character codes the scanner reacts to
  localparam logic [7:0] CHAR_HASH      = 8'h23;
  localparam logic [7:0] CHAR_COMMA     = 8'h2C;
  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_VT        = 8'h0B;
  localparam logic [7:0] CHAR_FF        = 8'h0C;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;

  // Largest value of a 24-bit result field
  localparam logic [23:0] FIELD_MAX = 24'hFFFFFF;

  // One input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]  token_kind;
    logic [23:0] first_offset;
    logic [23:0] token_length;
    logic [23:0] newline_total;
    logic        too_long;
    logic        unterminated;
    logic        last_of_run;
  } result_t;

  // Up to two results written into the result queue in one cycle
  typedef struct packed {
    logic    valid_a;
    logic    valid_b;
    result_t res_a;
    result_t res_b;
  } push_t;

  // Whitespace test: space, tab, LF, CR, FF, VT
  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_LF) ||
           (b == CHAR_CR) || (b == CHAR_FF) || (b == CHAR_VT);
  endfunction

  // Clamp a 32-bit count to the 24-bit field range
  function automatic logic [23:0] clamp24(input logic [31:0] v);
    return (v > 32'(FIELD_MAX)) ? FIELD_MAX : v[23:0];
  endfunction

endpackage

// ===== design/config_text_tokenizer_top.sv =====
// Top level of the config text tokenizer: scanner plus result queue.
//
//   channel  | valid      | stall      | payload   | transaction
//   ---------+------------+------------+-----------+-------------------------------
//   input    | data_valid | data_stall | data_item | one byte or end-of-data mark
//   output   | tok_valid  | tok_stall  | tok_item  | one token result
//
// One input transaction per cycle while data_stall is low; its results (zero to two)
// enter the result queue at that edge and reach the output behind any already queued.
// data_stall rises when the four-entry result queue has fewer than two free
// entries, so a stalled output holds the input back once three results are queued.
// rst is synchronous: scanner returns to between-tokens at offset zero, queue empties.
// After the end token every input transaction is taken and dropped until reset.
`timescale 1ns / 1ps

module config_text_tokenizer_top #(
  parameter int MAX_TOKEN_BYTES = 256,
  parameter int OFFSET_BITS     = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              data_valid,
  output logic              data_stall,
  input  ctt_pkg::item_t    data_item,
  output logic              tok_valid,
  input  logic              tok_stall,
  output ctt_pkg::result_t  tok_item
);

  logic           take;
  logic           full;
  ctt_pkg::push_t push;

  // Accept whenever the queue has two free entries
  assign data_stall = full;
  assign take       = data_valid && !full;

  ctt_scanner #(
    .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_scanner (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (data_item),
    .push (push)
  );

  ctt_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_item  (tok_item)
  );

endmodule

// ===== design/ctt_scanner.sv =====
// Byte scanner: mode, offset and newline state, and token result generation.
`timescale 1ns / 1ps

module ctt_scanner #(
  parameter int MAX_TOKEN_BYTES = 256,
  parameter int OFFSET_BITS     = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  ctt_pkg::item_t  item,
  output ctt_pkg::push_t  push
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_IDENT,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_DONE,
    MODE_OWED
  } mode_t;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  mode_t                  mode, mode_byte, mode_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] start, start_next;
  logic [23:0]            nl, nl_next;
  logic [OFFSET_BITS-1:0] len_byte, len_end;
  logic                   live, lf, blank, lf_seen;
  logic                   c0v, c1v;
  ctt_pkg::result_t       c0, c1, c_end;
  ctt_pkg::push_t         push_raw;

  // Build one result; last_of_run is set afterwards
  function automatic ctt_pkg::result_t make_tok(
    input logic [1:0]             kind,
    input logic [OFFSET_BITS-1:0] st,
    input logic [OFFSET_BITS-1:0] ln,
    input logic [23:0]            nlc,
    input logic                   too,
    input logic                   unt
  );
    ctt_pkg::result_t r;
    r.token_kind    = kind;
    r.first_offset  = ctt_pkg::clamp24(32'(st));
    r.token_length  = ctt_pkg::clamp24(32'(ln));
    r.newline_total = nlc;
    r.too_long      = too;
    r.unterminated  = unt;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic logic over_max(input logic [OFFSET_BITS-1:0] ln);
    return 33'(ln) >= 33'(MAX_TOKEN_BYTES);
  endfunction

  // Byte step, then end-of-data step, then pack the results
  always_comb begin
    live       = (mode != MODE_DONE) && (mode != MODE_OWED);
    lf         = (item.data_byte == ctt_pkg::CHAR_LF);
    blank      = ctt_pkg::is_blank(item.data_byte);
    len_byte   = pos - start;
    mode_byte  = mode;
    start_next = start;
    lf_seen    = 1'b0;
    c0v        = 1'b0;
    c0         = '0;

    if (live && item.has_byte) begin
      unique case (mode)
        MODE_IDLE: begin
          if (item.data_byte == ctt_pkg::CHAR_HASH) begin
            mode_byte = MODE_COMMENT;
          end else if (blank) begin
            lf_seen = lf;
          end else begin
            start_next = pos;
            mode_byte  = (item.data_byte == ctt_pkg::CHAR_QUOTE) ? MODE_STRING : MODE_IDENT;
          end
        end
        MODE_COMMENT: begin
          if (lf) begin
            lf_seen   = 1'b1;
            mode_byte = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (blank || item.data_byte == ctt_pkg::CHAR_COMMA) begin
            c0v = 1'b1;
            c0  = make_tok(ctt_pkg::KIND_IDENT, start, len_byte, nl,
                           over_max(len_byte), 1'b0);
            if (item.data_byte == ctt_pkg::CHAR_COMMA) begin
              start_next = pos;
            end else begin
              lf_seen   = lf;
              mode_byte = MODE_IDLE;
            end
          end
        end
        MODE_STRING: begin
          if (item.data_byte == ctt_pkg::CHAR_QUOTE) begin
            // closing quote belongs to the token unless the offset is pinned
            c0v       = 1'b1;
            c0        = make_tok(ctt_pkg::KIND_STRING, start,
                                 (pos != POS_MAX) ? len_byte + 1'b1 : len_byte, nl,
                                 over_max(len_byte), 1'b0);
            mode_byte = MODE_IDLE;
          end else if (item.data_byte == ctt_pkg::CHAR_BACKSLASH) begin
            mode_byte = MODE_ESCAPE;
          end else begin
            lf_seen = lf;
          end
        end
        MODE_ESCAPE: begin
          lf_seen   = lf;
          mode_byte = MODE_STRING;
        end
        default: begin
        end
      endcase
    end

    nl_next  = (lf_seen && nl != ctt_pkg::FIELD_MAX) ? nl + 24'd1 : nl;
    pos_next = (live && item.has_byte && pos != POS_MAX) ? pos + 1'b1 : pos;
    len_end  = pos_next - start_next;

    // Close an open token at end of data
    c1v = live && item.is_last &&
          (mode_byte == MODE_IDENT || mode_byte == MODE_STRING || mode_byte == MODE_ESCAPE);
    c1  = make_tok((mode_byte == MODE_IDENT) ? ctt_pkg::KIND_IDENT : ctt_pkg::KIND_STRING,
                   start_next, len_end, nl_next, over_max(len_end),
                   mode_byte != MODE_IDENT);
    c_end = make_tok(ctt_pkg::KIND_END, pos_next, '0, nl_next, 1'b0, 1'b0);

    push_raw  = '0;
    mode_next = mode_byte;
    if (mode == MODE_OWED) begin
      push_raw.valid_a = 1'b1;
      push_raw.res_a   = c_end;
      mode_next        = MODE_DONE;
    end else if (live) begin
      if (c0v) begin
        push_raw.valid_a = 1'b1;
        push_raw.res_a   = c0;
        push_raw.valid_b = c1v || item.is_last;
        push_raw.res_b   = c1v ? c1 : c_end;
      end else if (c1v) begin
        push_raw.valid_a = 1'b1;
        push_raw.res_a   = c1;
        push_raw.valid_b = 1'b1;
        push_raw.res_b   = c_end;
      end else if (item.is_last) begin
        push_raw.valid_a = 1'b1;
        push_raw.res_a   = c_end;
      end
      if (item.is_last) begin
        mode_next = (c0v && c1v) ? MODE_OWED : MODE_DONE;
      end
    end

    // Mark the final result of this transaction
    if (push_raw.valid_b) begin
      push_raw.res_b.last_of_run = 1'b1;
    end else if (push_raw.valid_a) begin
      push_raw.res_a.last_of_run = 1'b1;
    end

    push         = push_raw;
    push.valid_a = push_raw.valid_a && take;
    push.valid_b = push_raw.valid_b && take;
  end

  // Hold scan state; advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      pos   <= '0;
      start <= '0;
      nl    <= '0;
    end else if (take) begin
      mode  <= mode_next;
      pos   <= pos_next;
      start <= start_next;
      nl    <= nl_next;
    end
  end

`ifndef SYNTH
  a_b_needs_a: assert property (@(posedge clk) disable iff (rst)
    push.valid_b |-> push.valid_a)
    else $error("second result pushed without a first");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_DONE |=> mode == MODE_DONE)
    else $error("scanner left the done mode");

  a_owed_end: assert property (@(posedge clk) disable iff (rst)
    (take && mode == MODE_OWED) |->
      (push.valid_a && !push.valid_b && push.res_a.token_kind == ctt_pkg::KIND_END))
    else $error("owed end token not sent alone");
`endif

endmodule

// ===== design/ctt_result_queue.sv =====
// Four-entry result queue: up to two writes and one read per cycle.
`timescale 1ns / 1ps

module ctt_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  ctt_pkg::push_t    push,
  output logic              full,
  output logic              tok_valid,
  input  logic              tok_stall,
  output ctt_pkg::result_t  tok_item
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  ctt_pkg::result_t mem [DEPTH];
  logic [PW-1:0]    rd_ptr, wr_ptr, wr_ptr_b;
  logic [PW:0]      count, count_next;
  logic [1:0]       n_push;
  logic             pop;

  // Show the head entry; stall the scanner unless two slots are free
  always_comb begin
    tok_valid  = (count != '0);
    tok_item   = mem[rd_ptr];
    full       = count > (PW+1)'(DEPTH - 2);
    pop        = tok_valid && !tok_stall;
    n_push     = 2'(push.valid_a) + 2'(push.valid_b);
    wr_ptr_b   = wr_ptr + 1'b1;
    count_next = count + (PW+1)'(n_push) - (PW+1)'(pop);
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      wr_ptr <= wr_ptr + PW'(n_push);
      count  <= count_next;
    end
  end

  // Write entries
  always_ff @(posedge clk) begin
    if (push.valid_a) begin
      mem[wr_ptr] <= push.res_a;
    end
    if (push.valid_b) begin
      mem[wr_ptr_b] <= push.res_b;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(DEPTH))
    else $error("result queue count exceeds depth");

  a_room_on_push: assert property (@(posedge clk) disable iff (rst)
    push.valid_a |-> count <= (PW+1)'(DEPTH - 2))
    else $error("results pushed without two free entries");
`endif

endmodule
